// File: rtl/sqe_pkg.sv
`default_nettype none
package sqe_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_PRINT = 3'd1,
        OP_PEEK  = 3'd2,
        OP_POP   = 3'd3,
        OP_SWAP  = 3'd4,
        OP_CLEAR = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_PUSH_ARG    = 3'd1,
        STAT_PRINT_ARG   = 3'd2,
        STAT_PEEK_EMPTY  = 3'd3,
        STAT_POP_EMPTY   = 3'd4,
        STAT_SWAP_SHORT  = 3'd5,
        STAT_FULL        = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_TOP,
        CELL_PUSH_TAIL,
        CELL_POP,
        CELL_SWAP,
        CELL_ROTATE
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    pos;    // tail slot for push at tail, last slot for rotate
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/sqe_cell.sv
`default_nettype none
module sqe_cell
    import sqe_pkg::*;
(
    input  wire                   clk,
    input  cell_ctrl_t            ctrl,
    input  wire  [IDX_W-1:0]      idx,
    input  wire  [DATA_W-1:0]     prev_data,   // from the cell nearer the top
    input  wire  [DATA_W-1:0]     next_data,   // from the cell nearer the tail
    input  wire  [DATA_W-1:0]     head_data,   // top cell, closes the ring on rotate
    output logic [DATA_W-1:0]     data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:      data_next = data_reg;
            CELL_PUSH_TOP:  data_next = prev_data;
            CELL_PUSH_TAIL:
            begin
                if (idx == ctrl.pos)
                    data_next = ctrl.value;
            end
            CELL_POP:       data_next = next_data;
            CELL_SWAP:
            begin
                if (idx == IDX_W'(0))
                    data_next = next_data;
                else if (idx == IDX_W'(1))
                    data_next = prev_data;
            end
            CELL_ROTATE:
            begin
                if (idx == ctrl.pos)
                    data_next = head_data;
                else if (idx < ctrl.pos)
                    data_next = next_data;
            end
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// File: rtl/stack_queue_engine.sv
`default_nettype none
// Stack/queue engine: a row of DEPTH register cells, cell 0 holding the top element, that
// runs push, print all, peek, pop, swap and clear. Every command except a non-empty print
// has its result in the output register in the cycle after its transfer; a new command is
// taken as soon as the output register is empty or being drained, so with m_tready held
// high commands flow at one per cycle. Print all of n elements streams one element per
// cycle while the output is free, by rotating the cell chain once round, leaving the order
// as it was; no command is taken during that walk. Unused operation codes give no result.
module stack_queue_engine
    import sqe_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data,       // queue_mode
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [31:0]         s_tdata,        // value
    input  wire  [3:0]          s_tuser,        // operation[2:0], argument_bad[3]
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [31:0]         m_tdata,        // data
    output logic [3:0]          m_tuser,        // status[2:0], data_valid[3]
    output logic                m_tlast
);

    typedef enum logic {
        S_IDLE,
        S_PRINT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               mode_reg;
    logic               m_tvalid_reg;
    logic [DATA_W-1:0]  m_data_reg;
    status_t            m_status_reg;
    logic               m_dvalid_reg;
    logic               m_last_reg;

    logic               accept;
    logic               out_free;
    op_t                op;
    logic               arg_bad;
    cell_ctrl_t         ctrl;
    logic               res_load;
    status_t            res_status;
    logic               res_dvalid;
    logic               res_last;
    logic [DATA_W-1:0]  head;
    logic [DATA_W-1:0]  cell_data [DEPTH];
    logic [IDX_W-1:0]   tail_pos;
    logic [IDX_W-1:0]   last_pos;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser[2:0]);
    assign arg_bad   = s_tuser[3];
    assign head      = cell_data[0];
    assign tail_pos  = count_reg[IDX_W-1:0];
    assign last_pos  = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        ctrl.op     = CELL_HOLD;
        ctrl.pos    = tail_pos;
        ctrl.value  = s_tdata;
        res_load    = 1'b0;
        res_status  = STAT_OK;
        res_dvalid  = 1'b0;
        res_last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    case (op)
                        OP_PUSH:
                        begin
                            if (arg_bad)
                                res_status = STAT_PUSH_ARG;
                            else if (count_reg == CNT_W'(DEPTH))
                                res_status = STAT_FULL;
                            else
                            begin
                                ctrl.op    = mode_reg ? CELL_PUSH_TAIL : CELL_PUSH_TOP;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PRINT:
                        begin
                            if (arg_bad)
                                res_status = STAT_PRINT_ARG;
                            else if (count_reg != '0)
                            begin
                                res_load    = 1'b0;
                                remain_next = count_reg;
                                state_next  = S_PRINT;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (count_reg == '0)
                                res_status = STAT_PEEK_EMPTY;
                            else
                                res_dvalid = 1'b1;
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                                res_status = STAT_POP_EMPTY;
                            else
                            begin
                                ctrl.op    = CELL_POP;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SWAP:
                        begin
                            if (count_reg < CNT_W'(2))
                                res_status = STAT_SWAP_SHORT;
                            else
                                ctrl.op = CELL_SWAP;
                        end
                        OP_CLEAR:
                            count_next = '0;
                        default:
                            res_load = 1'b0;
                    endcase
                end
            end
            S_PRINT:
            begin
                if (out_free)
                begin
                    // emit the top, then rotate so the next element comes up
                    res_load    = 1'b1;
                    res_dvalid  = 1'b1;
                    res_last    = (remain_reg == CNT_W'(1));
                    ctrl.op     = CELL_ROTATE;
                    ctrl.pos    = last_pos;
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            remain_reg   <= '0;
            mode_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (res_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_data_reg   <= res_dvalid ? head : '0;
            m_status_reg <= res_status;
            m_dvalid_reg <= res_dvalid;
            m_last_reg   <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_dvalid_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = ctrl.value;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        sqe_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .idx       (IDX_W'(i)),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (head),
            .data      (cell_data[i])
        );
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_print_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRINT) |-> (remain_reg != '0 && remain_reg <= count_reg))
        else $error("print walk counter out of range");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser[2:0] == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left elements behind");

    a_data_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == STAT_OK))
        else $error("data reported with an error status");

    a_print_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRINT) |-> !accept)
        else $error("command taken during print walk");
`endif

endmodule
`default_nettype wire
